### rtl/core/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Field widths, stream packing and the result record shared by the page
// frame store and its port checker.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // default sizing
   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_BITS_DEF  = 16;

   // field widths of the stream payloads
   localparam int PAGE_W = 16;
   localparam int SLOT_W = 3;
   localparam int CFG_W  = 4;

   // frames active after reset
   localparam logic [CFG_W-1:0] RESET_FRAMES = 4'd8;

   // stream data widths, padded to whole bytes
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_BITS    = 1 + SLOT_W + 1 + PAGE_W;
   localparam int RSP_TDATA_W = 24;

   // result field positions inside rsp_tdata
   localparam int RSP_HIT_BIT  = 0;
   localparam int RSP_SLOT_LSB = 1;
   localparam int RSP_EV_BIT   = 4;
   localparam int RSP_EVP_LSB  = 5;

   // result record, first field in the highest bits
   typedef struct packed {
      logic [PAGE_W-1:0] evicted_page;
      logic              evicted_valid;
      logic [SLOT_W-1:0] slot;
      logic              hit;
   } rsp_type;

endpackage

### rtl/core/lru_page_replacement.sv
// A request moves from the request register to the result register when that one is free.
// Throughput: one request per cycle while rsp_* is not stalled; the tag compare, age-rank
//   update and frame write for a request all complete combinationally between the request
//   register and the result register.
// Reset: synchronous, active high; empties every frame, selects 8 active frames
//   and drops any request or result in flight. Reset takes no clearing pass.
// ----------------------------------------------------------------------------
// LRU page frame store
// Fully associative set of page frames with least-recently-used replacement
// kept as per-frame age ranks; one result per requested page.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lrupr_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [15:0] page
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lrupr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [0] hit, [3:1] slot,
                                                           // [4] evicted_valid,
                                                           // [20:5] evicted_page
   // frames_in_use register
   input  logic                               csr_wr_en,
   input  logic [lrupr_pkg::CFG_W-1:0]        csr_wr_data
);
   import lrupr_pkg::*;

   localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [5:0] MaxCnt = 6'(MAX_FRAMES);

   // request register
   logic                 in_valid_ff;
   logic [PAGE_BITS-1:0] in_page_ff;
   // result register
   logic                 out_valid_ff;
   rsp_type              out_ff;
   // frame store
   logic [PAGE_BITS-1:0] page_ff   [MAX_FRAMES];
   logic [PAGE_BITS-1:0] page_in   [MAX_FRAMES];
   logic [AW-1:0]        age_ff    [MAX_FRAMES];
   logic [AW-1:0]        age_in    [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [MAX_FRAMES-1:0] active_ff, active_in;
   logic [AW-1:0]        top_rank_ff, top_rank_in;

   logic advance, fire;
   logic [PAGE_BITS+PAGE_W-1:0] req_page_ext;

   // lookup results
   logic [MAX_FRAMES-1:0] match, empty, oldest;
   logic                  hit_any, empty_any, evict;
   logic [AW-1:0]         hit_idx, empty_idx, victim_idx, slot_sel;
   logic [AW+SLOT_W-1:0]  slot_ext;
   logic [PAGE_W+PAGE_BITS-1:0] evp_ext;
   rsp_type               rsp_in;

   // configuration decode
   logic [CFG_W-1:0] cfg_raw;
   logic [5:0]       cfg_cnt;

   // handshake: result register frees the request register
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_BITS)'(0), out_ff};

   assign req_page_ext = {{PAGE_BITS{1'b0}}, req_tdata[PAGE_W-1:0]};

   // clamp frames_in_use into 1..MAX_FRAMES
   always_comb begin
      cfg_raw = reset ? RESET_FRAMES : csr_wr_data;
      cfg_cnt = (cfg_raw == '0) ? 6'd1 : {2'b00, cfg_raw};
      if (cfg_cnt > MaxCnt) begin
         cfg_cnt = MaxCnt;
      end
      for (int i = 0; i < MAX_FRAMES; i++) begin
         active_in[i] = 6'(i) < cfg_cnt;
      end
      top_rank_in = AW'(cfg_cnt - 6'd1);
   end

   // tag compare and slot choice
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i]  = active_ff[i] && valid_ff[i] && (page_ff[i] == in_page_ff);
         empty[i]  = active_ff[i] && !valid_ff[i];
         oldest[i] = active_ff[i] && valid_ff[i] && (age_ff[i] == top_rank_ff);
      end
      hit_any   = |match;
      empty_any = |empty;
      evict     = !hit_any && !empty_any;
      // lowest matching slot
      hit_idx = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = AW'(i);
         end
      end
      // highest empty slot and highest oldest slot
      empty_idx  = '0;
      victim_idx = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (empty[i]) begin
            empty_idx = AW'(i);
         end
         if (oldest[i]) begin
            victim_idx = AW'(i);
         end
      end
      if (hit_any) begin
         slot_sel = hit_idx;
      end else if (empty_any) begin
         slot_sel = empty_idx;
      end else begin
         slot_sel = victim_idx;
      end
   end

   // result record
   always_comb begin
      slot_ext = {{SLOT_W{1'b0}}, slot_sel};
      evp_ext  = {{PAGE_W{1'b0}}, page_ff[slot_sel]};
      rsp_in.hit           = hit_any;
      rsp_in.slot          = slot_ext[SLOT_W-1:0];
      rsp_in.evicted_valid = evict;
      rsp_in.evicted_page  = evict ? evp_ext[PAGE_W-1:0] : '0;
   end

   // age ranks: selected frame newest; others age by one (on a hit only the younger ones)
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         page_in[i]  = page_ff[i];
         age_in[i]   = age_ff[i];
         valid_in[i] = valid_ff[i];
         if (AW'(i) == slot_sel) begin
            age_in[i]   = '0;
            valid_in[i] = 1'b1;
            if (!hit_any) begin
               page_in[i] = in_page_ff;
            end
         end else if (active_ff[i] && valid_ff[i]
                      && (!hit_any || (age_ff[i] < age_ff[slot_sel]))) begin
            age_in[i] = age_ff[i] + AW'(1);
         end
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_page_ff <= req_page_ext[PAGE_BITS-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (fire) begin
         out_ff <= rsp_in;
      end
   end

   // frame store state; a register write empties every frame
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         valid_ff    <= '0;
         active_ff   <= active_in;
         top_rank_ff <= top_rank_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (fire) begin
         valid_ff <= valid_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   // page tags, no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            page_ff[i] <= page_in[i];
         end
      end
   end

endmodule

### rtl/core/lrupr_checker.sv
// ----------------------------------------------------------------------------
// LRU page replacement port checker
// Watches the stream ports of the page frame store over time.
// ----------------------------------------------------------------------------
module lrupr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [lrupr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lrupr_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lrupr_pkg::*;

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // requests stall only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request side stalled without back-pressure");

   // a hit never replaces a page
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_HIT_BIT] |->
         !rsp_tdata[RSP_EV_BIT] && (rsp_tdata[RSP_EVP_LSB +: PAGE_W] == '0))
      else $error("hit reported an evicted page");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page frame store testbench
// Streams page requests into the frame store and checks every result against
// an in-bench LRU predictor that tracks the frames and their age ranks. The
// run starts with a directed fill, hit and eviction sequence. Random phases
// follow, each under a new frames_in_use setting, with the extremes among
// them, and a new pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import lrupr_pkg::*;

   localparam int FRAMES      = MAX_FRAMES_DEF;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 160;
   localparam int STALL_LIMIT = 5000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   // predictor copy of the frame table
   logic [PAGE_W-1:0] held_page  [FRAMES];
   logic              held_valid [FRAMES];
   int unsigned       held_age   [FRAMES];
   logic [CFG_W-1:0]  frames_reg;

   logic [PAGE_W-1:0] page_backlog [$];
   rsp_type           awaited_rsp  [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;

   lru_page_replacement dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // empty every frame and take a new frames_in_use value
   function automatic void set_frames(logic [CFG_W-1:0] value);
      frames_reg = value;
      for (int i = 0; i < FRAMES; i++) begin
         held_page[i]  = '0;
         held_valid[i] = 1'b0;
         held_age[i]   = 0;
      end
   endfunction

   // make slot s the most recent; valid frames younger than limit age by one
   function automatic void promote(int s, int unsigned limit, int n);
      for (int i = 0; i < n; i++) begin
         if (i != s && held_valid[i] && held_age[i] < limit)
            held_age[i]++;
      end
      held_age[s] = 0;
   endfunction

   // look up one page, update the frames and return the result it yields
   function automatic rsp_type lru_lookup(logic [PAGE_W-1:0] page);
      int          n;
      int          s;
      bit          found;
      bit          any;
      int unsigned oldest;
      rsp_type     r;
      n      = (frames_reg == 0) ? 1 : (frames_reg > FRAMES) ? FRAMES : int'(frames_reg);
      s      = 0;
      found  = 1'b0;
      any    = 1'b0;
      oldest = 0;
      r      = '0;
      for (int i = 0; i < n && !found; i++) begin
         if (held_valid[i] && held_page[i] == page) begin
            s     = i;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         promote(s, held_age[s], n);
      end else begin
         // fill the highest empty slot first
         for (int i = n - 1; i >= 0 && !any; i--) begin
            if (!held_valid[i]) begin
               s   = i;
               any = 1'b1;
            end
         end
         if (any) begin
            held_valid[s] = 1'b1;
            held_page[s]  = page;
         end else begin
            // replace the oldest frame, scanning from the top
            for (int i = n - 1; i >= 0; i--) begin
               if (held_valid[i] && (!any || held_age[i] > oldest)) begin
                  oldest = held_age[i];
                  s      = i;
                  any    = 1'b1;
               end
            end
            r.evicted_valid = 1'b1;
            r.evicted_page  = held_page[s];
            held_page[s]    = page;
         end
         promote(s, 32'hFFFF_FFFF, n);
      end
      r.slot = s[SLOT_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch on %s at %0t: expected %0h, got %0h", name, $time, want, got);
      end
   endfunction

   // request driver: predict on each accepted transaction, then offer the next page
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_rsp.push_back(lru_lookup(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (page_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= page_backlog.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each accepted transaction with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result at %0t: %0h", $time, rsp_tdata);
            end else begin
               want = awaited_rsp.pop_front();
               check_field("hit", want.hit, got.hit);
               check_field("slot", want.slot, got.slot);
               check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
               check_field("evicted_page", want.evicted_page, got.evicted_page);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // hold until every queued page has gone and every result has come back
   task automatic drain();
      while (page_backlog.size() != 0 || req_tvalid || awaited_rsp.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0]  settings [PHASES];
      logic [PAGE_W-1:0] pool [$];
      int                n;
      settings = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd2, 4'd4,
                   4'd8, 4'd9, 4'd3, 4'd7, 4'd5, 4'd6};
      set_frames(RESET_FRAMES);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // fill all eight frames, then mix hits on oldest and middle frames with evictions
      page_backlog = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h0002,
                       16'h0003, 16'h0004, 16'h0000, 16'hFFFF, 16'h0004, 16'h1234,
                       16'h5555, 16'h0002, 16'h8000, 16'h7FFF, 16'h0000, 16'h1234,
                       16'h00FF, 16'hFF00};
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         // write the register while idle; this also empties the frames
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= settings[phase];
         @(posedge clock);
         set_frames(settings[phase]);
         csr_wr_en   <= 1'b0;

         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase

         // working set a little larger than the active frames, with the extremes kept in
         n = (settings[phase] == 0) ? 1 :
             (settings[phase] > FRAMES) ? FRAMES : int'(settings[phase]);
         pool = '{16'h0000, 16'hFFFF};
         repeat (n + $urandom_range(0, 3))
            pool.push_back(PAGE_W'($urandom_range(16'hFFFF)));
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 80)
               page_backlog.push_back(pool[$urandom_range(pool.size() - 1)]);
            else
               page_backlog.push_back(PAGE_W'($urandom_range(16'hFFFF)));
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (awaited_rsp.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
